// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the project.
// No dependencies; take it in with a plain include of the file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("u8d assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("u8d assertion failed");

`endif

// File: rtl/core/u8d_pkg.sv
// Package of the UTF-8 stream decoder: widths, constants and the command type.
// No dependencies; every other file of the decoder imports it.
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CP_W        = 21;
  localparam int IDX_W       = 16;
  // Queue depth between front and back; must be a power of two.
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  localparam logic [CP_W-1:0] QMARK_CP = CP_W'(63);

  // One beat of work for the back part: n_q replacement marks, then an
  // optional main result.
  typedef struct packed {
    logic [2:0]      n_q;
    logic            main_v;
    logic [CP_W-1:0] main_cp;
    logic            main_rep;
    logic            eot;
  } cmd_t;

endpackage

// File: rtl/core/u8d_ifs.sv
// Channel interfaces of the decoder: byte input and decoded result.
// Depends on u8d_pkg for the field widths.
`timescale 1ns / 1ps

interface u8d_in_if import u8d_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic             replaced;
  logic [IDX_W-1:0] char_index;
  logic             last_of_run;
  logic             text_done;

  modport source (output valid, output code_point, output replaced, output char_index,
                  output last_of_run, output text_done, input ready);
  modport sink (input valid, input code_point, input replaced, input char_index,
                input last_of_run, input text_done, output ready);
endinterface

// File: rtl/core/u8d_front.sv
// Front part: accepts bytes, tracks the pending sequence and issues commands.
// Depends on u8d_pkg and u8d_in_if.
`timescale 1ns / 1ps

module u8d_front import u8d_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  u8d_in_if.sink  in_ch,
  input  logic    q_full,
  output logic    push,
  output cmd_t    cmd
);

  logic [1:0]      exp_r, exp_nxt;
  logic [1:0]      taken_r, taken_nxt;
  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [1:0]      taken_inc;
  logic [2:0]      n_pre;
  logic [1:0]      lead_exp;
  logic [CP_W-1:0] lead_val;
  logic [7:0]      b;
  logic            eot;
  logic            accept;

  assign b           = in_ch.in_byte;
  assign eot         = in_ch.end_of_text;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign push        = accept && ((cmd.n_q != 3'd0) || cmd.main_v);

  always_comb begin
    lead_exp = 2'd0;
    lead_val = '0;
    priority if (b[7:5] == 3'b110) begin
      lead_exp = 2'd1;
      lead_val = CP_W'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      lead_exp = 2'd2;
      lead_val = CP_W'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      lead_exp = 2'd3;
      lead_val = CP_W'(b[2:0]);
    end else begin
      lead_exp = 2'd0;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.eot     = eot;
    exp_nxt     = exp_r;
    taken_nxt   = taken_r;
    partial_nxt = partial_r;
    taken_inc   = taken_r + 2'd1;
    n_pre       = 3'd0;
    if ((exp_r != 2'd0) && (b[7:6] == 2'b10)) begin
      if (taken_inc == exp_r) begin
        cmd.main_v  = 1'b1;
        cmd.main_cp = {partial_r[CP_W-7:0], b[5:0]};
        exp_nxt     = 2'd0;
        taken_nxt   = 2'd0;
        partial_nxt = '0;
      end else begin
        taken_nxt   = taken_inc;
        partial_nxt = {partial_r[CP_W-7:0], b[5:0]};
        if (eot) begin
          cmd.n_q = {1'b0, taken_inc} + 3'd1;
        end
      end
    end else begin
      if (exp_r != 2'd0) begin
        n_pre = {1'b0, taken_r} + 3'd1;
      end
      cmd.n_q = n_pre;
      if (!b[7]) begin
        cmd.main_v  = 1'b1;
        cmd.main_cp = CP_W'(b);
        exp_nxt     = 2'd0;
        taken_nxt   = 2'd0;
        partial_nxt = '0;
      end else if (lead_exp != 2'd0) begin
        exp_nxt     = lead_exp;
        taken_nxt   = 2'd0;
        partial_nxt = lead_val;
        if (eot) begin
          cmd.n_q = n_pre + 3'd1;
        end
      end else begin
        cmd.main_v   = 1'b1;
        cmd.main_cp  = QMARK_CP;
        cmd.main_rep = 1'b1;
        exp_nxt      = 2'd0;
        taken_nxt    = 2'd0;
        partial_nxt  = '0;
      end
    end
    if (eot) begin
      exp_nxt     = 2'd0;
      taken_nxt   = 2'd0;
      partial_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r     <= 2'd0;
      taken_r   <= 2'd0;
      partial_r <= '0;
    end else if (accept) begin
      exp_r     <= exp_nxt;
      taken_r   <= taken_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

// File: rtl/core/u8d_fifo.sv
// Short command queue between the front and back parts.
// Depends on u8d_pkg for the command type and depth.
`timescale 1ns / 1ps

module u8d_fifo import u8d_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic empty,
  output logic full
);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == (PTR_W+1)'(FIFO_DEPTH));
  assign rd_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/u8d_back.sv
// Back part: expands each command into result beats and keeps the index.
// Depends on u8d_pkg and u8d_out_if.
`timescale 1ns / 1ps

module u8d_back import u8d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      q_empty,
  output logic      pop,
  u8d_out_if.source out_ch
);

  logic [2:0]             sub_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic                   out_valid_r;
  logic [CP_W-1:0]        cp_r;
  logic                   rep_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   last_r;
  logic                   done_r;
  logic [2:0]             total;
  logic                   is_last;
  logic                   load;
  logic                   emit;
  logic                   is_q;

  assign total   = cmd.n_q + {2'b00, cmd.main_v};
  assign is_last = ((sub_r + 3'd1) == total);
  assign is_q    = (sub_r < cmd.n_q);
  assign load    = !out_valid_r || out_ch.ready;
  assign emit    = load && !q_empty;
  assign pop     = emit && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= 3'd0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= !q_empty;
      end
      if (emit) begin
        sub_r <= is_last ? 3'd0 : sub_r + 3'd1;
        if (is_last && cmd.eot) begin
          count_r <= '0;
        end else if (count_r != '1) begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r   <= is_q ? QMARK_CP : cmd.main_cp;
      rep_r  <= is_q ? 1'b1 : cmd.main_rep;
      idx_r  <= IDX_W'(count_r);
      last_r <= is_last;
      done_r <= is_last && cmd.eot;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_point  = cp_r;
  assign out_ch.replaced    = rep_r;
  assign out_ch.char_index  = idx_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.text_done   = done_r;

endmodule

// File: rtl/core/utf8_stream_decoder.sv
// Channel  | Dir | Beat contents
// in_ch    | in  | in_byte, end_of_text
// out_ch   | out | code_point, replaced, char_index, last_of_run, text_done
//
// One byte is taken per cycle while the command queue has room.
// A byte causing k results (k is 0 to 4) keeps the back part busy until all k are sent;
// the four-entry queue absorbs these bursts.
// A byte's results are registered in the command queue and then in the back part's output registers.
// Reset is synchronous; the block is ready in the first cycle after it.
// Stalls on out_ch fill the queue and then drop in_ch.ready.
// Depends on u8d_pkg, u8d_ifs, u8d_front, u8d_fifo and u8d_back.
`timescale 1ns / 1ps

module utf8_stream_decoder import u8d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch
);

  cmd_t wr_cmd;
  cmd_t rd_cmd;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  u8d_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (wr_cmd)
  );

  u8d_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .empty  (q_empty),
    .full   (q_full)
  );

  u8d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (rd_cmd),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/core/u8d_checker.sv
// Port-level checker of the UTF-8 stream decoder and its bind statement.
// Depends on u8d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8d_checker import u8d_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CP_W-1:0]  code_point,
  input logic             replaced,
  input logic [IDX_W-1:0] char_index,
  input logic             last_of_run,
  input logic             text_done
);

  logic [COUNT_WIDTH-1:0]  exp_idx_r;
  logic                    beat;
  logic [CP_W+IDX_W+2:0]   payload;

  assign beat    = out_valid && out_ready;
  assign payload = {code_point, replaced, char_index, last_of_run, text_done};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (beat) begin
      if (text_done) begin
        exp_idx_r <= '0;
      end else if (exp_idx_r != '1) begin
        exp_idx_r <= exp_idx_r + 1'b1;
      end
    end
  end

  `U8D_ASSERT_IMP(a_rep_is_qmark, clk, rst_n, out_valid && replaced, code_point == QMARK_CP)
  `U8D_ASSERT_IMP(a_done_is_last, clk, rst_n, out_valid && text_done, last_of_run)
  `U8D_ASSERT_IMP(a_index_seq, clk, rst_n, beat, char_index == IDX_W'(exp_idx_r))
  `U8D_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(payload))

endmodule

bind utf8_stream_decoder u8d_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .code_point  (out_ch.code_point),
  .replaced    (out_ch.replaced),
  .char_index  (out_ch.char_index),
  .last_of_run (out_ch.last_of_run),
  .text_done   (out_ch.text_done)
);

// File: tb/tb_utf8_stream_decoder.sv
// Self-checking testbench of utf8_stream_decoder: directed and random texts,
// one result predicted per decoded character and compared beat by beat.
// Depends on u8d_pkg, u8d_ifs and the decoder RTL.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import u8d_pkg::*;

  typedef struct {
    logic [7:0]  b;
    logic        eot;
    int unsigned gap;
  } text_byte_t;

  typedef struct {
    logic [CP_W-1:0]  code_point;
    logic             replaced;
    logic [IDX_W-1:0] char_index;
    logic             last_of_run;
    logic             text_done;
  } char_result_t;

  localparam int RANDOM_BYTES = 350;
  localparam int MAX_PRINTED  = 50;

  // Bit 8 marks the final byte of a text.
  localparam logic [8:0] DIRECTED [28] = '{
    9'h000, 9'h07f, 9'h0c2, 9'h0a9, 9'h0e2, 9'h082, 9'h0ac,
    9'h0f0, 9'h09f, 9'h098, 9'h080, 9'h0f7, 9'h0bf, 9'h0bf, 9'h1bf,
    9'h0c0, 9'h080, 9'h0ed, 9'h0a0, 9'h080, 9'h080, 9'h0f8, 9'h0ff,
    9'h0e2, 9'h082, 9'h041, 9'h0f0, 9'h090
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_byte = 8'h00;
  logic       drv_eot = 1'b0;
  logic       snk_ready = 1'b0;
  logic       in_fire = 1'b0;
  logic       out_fire = 1'b0;

  int unsigned src_gap = 0;
  int unsigned snk_stall = 0;
  int unsigned snk_stall_max = 5;

  text_byte_t   text_bytes [$];
  char_result_t expected_chars [$];

  logic [1:0]             utf_need = '0;
  logic [1:0]             utf_got = '0;
  logic [CP_W-1:0]        utf_acc = '0;
  logic [COUNT_WIDTH-1:0] chr_count = '0;
  int                     run_len = 0;

  int err_count = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int results_checked = 0;
  int replacements_seen = 0;

  u8d_in_if  in_ch ();
  u8d_out_if out_ch ();

  assign in_ch.valid       = drv_valid;
  assign in_ch.in_byte     = drv_byte;
  assign in_ch.end_of_text = drv_eot;
  assign out_ch.ready      = snk_ready;

  utf8_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", expected_chars.size());
    $display("tb_utf8_stream_decoder failed");
    $finish;
  end

  task automatic note_mismatch(string what, longint got, longint want);
    if (err_count < MAX_PRINTED) begin
      $display("Mismatch at result %0d: %s is %0h, expected %0h.",
               results_checked, what, got, want);
    end
    err_count++;
  endtask

  function automatic void push_char(logic [CP_W-1:0] cp, logic rep);
    char_result_t r;
    if (run_len >= 4) begin
      return;
    end
    r.code_point  = cp;
    r.replaced    = rep;
    r.char_index  = IDX_W'(chr_count);
    r.last_of_run = 1'b0;
    r.text_done   = 1'b0;
    expected_chars.push_back(r);
    run_len++;
    if (chr_count != '1) begin
      chr_count++;
    end
  endfunction

  function automatic void flush_partial();
    if (utf_need != 0) begin
      for (int i = 0; i <= utf_got; i++) begin
        push_char(QMARK_CP, 1'b1);
      end
      utf_need = '0;
      utf_got  = '0;
      utf_acc  = '0;
    end
  endfunction

  function automatic void begin_char(logic [7:0] b);
    utf_got = '0;
    if (b[7] == 1'b0) begin
      push_char(CP_W'(b), 1'b0);
    end else if (b[7:5] == 3'b110) begin
      utf_acc  = CP_W'(b[4:0]);
      utf_need = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      utf_acc  = CP_W'(b[3:0]);
      utf_need = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      utf_acc  = CP_W'(b[2:0]);
      utf_need = 2'd3;
    end else begin
      push_char(QMARK_CP, 1'b1);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eot);
    run_len = 0;
    if (utf_need != 0) begin
      if (b[7:6] == 2'b10) begin
        utf_acc = CP_W'({utf_acc, b[5:0]});
        utf_got++;
        if (utf_got >= utf_need) begin
          push_char(utf_acc, 1'b0);
          utf_need = '0;
          utf_got  = '0;
          utf_acc  = '0;
        end
      end else begin
        flush_partial();
        begin_char(b);
      end
    end else begin
      begin_char(b);
    end
    if (eot) begin
      flush_partial();
      chr_count = '0;
    end
    if (run_len > 0) begin
      expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
      if (eot) begin
        expected_chars[expected_chars.size() - 1].text_done = 1'b1;
      end
    end
  endfunction

  task automatic check_result();
    char_result_t want;
    if (expected_chars.size() == 0) begin
      note_mismatch("unexpected code_point", out_ch.code_point, 0);
      return;
    end
    want = expected_chars.pop_front();
    if (out_ch.code_point !== want.code_point) begin
      note_mismatch("code_point", out_ch.code_point, want.code_point);
    end
    if (out_ch.replaced !== want.replaced) begin
      note_mismatch("replaced", out_ch.replaced, want.replaced);
    end
    if (out_ch.char_index !== want.char_index) begin
      note_mismatch("char_index", out_ch.char_index, want.char_index);
    end
    if (out_ch.last_of_run !== want.last_of_run) begin
      note_mismatch("last_of_run", out_ch.last_of_run, want.last_of_run);
    end
    if (out_ch.text_done !== want.text_done) begin
      note_mismatch("text_done", out_ch.text_done, want.text_done);
    end
    if (want.replaced) begin
      replacements_seen++;
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_ch.valid && in_ch.ready;
      out_fire <= out_ch.valid && out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        check_result();
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.in_byte, in_ch.end_of_text);
      end
    end
  end

  always @(negedge clk) begin
    text_byte_t item;
    if (!rst_n) begin
      drv_valid <= 1'b0;
      drv_byte  <= 8'h00;
      drv_eot   <= 1'b0;
      src_gap   <= 0;
    end else if (in_fire || !drv_valid) begin
      if (src_gap != 0) begin
        drv_valid <= 1'b0;
        src_gap   <= src_gap - 1;
      end else if (text_bytes.size() != 0) begin
        item = text_bytes.pop_front();
        drv_byte  <= item.b;
        drv_eot   <= item.eot;
        drv_valid <= 1'b1;
        src_gap   <= item.gap;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    int unsigned stall;
    if (!rst_n) begin
      snk_ready <= 1'b0;
      snk_stall <= 0;
    end else begin
      stall = out_fire ? $urandom_range(0, snk_stall_max) : snk_stall;
      if (stall != 0) begin
        snk_ready <= 1'b0;
        snk_stall <= stall - 1;
      end else begin
        snk_ready <= 1'b1;
        snk_stall <= 0;
      end
    end
  end

  task automatic wait_quiet();
    while (text_bytes.size() != 0 || drv_valid || expected_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] lead_byte(int n_cont);
    unique case (n_cont)
      1: return {3'b110, 5'($urandom)};
      2: return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic queue_byte(logic [7:0] b, logic eot, int unsigned gap);
    text_byte_t item;
    item.b   = b;
    item.eot = eot;
    item.gap = gap;
    text_bytes.push_back(item);
    bytes_sent++;
    if (eot) begin
      texts_sent++;
    end
  endtask

  task automatic queue_text(int n_chars, int unsigned gap_max);
    logic [7:0] t [$];
    logic [7:0] b;
    int n;
    int k;
    for (int c = 0; c < n_chars; c++) begin
      k = $urandom_range(0, 99);
      if (k < 25) begin
        t.push_back(8'($urandom_range(0, 127)));
      end else if (k < 70) begin
        n = (k < 45) ? 1 : (k < 60) ? 2 : 3;
        t.push_back(lead_byte(n));
        for (int j = 0; j < n; j++) begin
          t.push_back(cont_byte());
        end
      end else if (k < 85) begin
        n = $urandom_range(1, 3);
        t.push_back(lead_byte(n));
        for (int j = $urandom_range(0, n - 1); j > 0; j--) begin
          t.push_back(cont_byte());
        end
        do begin
          b = 8'($urandom);
        end while (b[7:6] == 2'b10);
        t.push_back(b);
      end else if (k < 92) begin
        t.push_back(cont_byte());
      end else begin
        t.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      t.push_back(lead_byte(n));
      for (int j = $urandom_range(0, n - 1); j > 0; j--) begin
        t.push_back(cont_byte());
      end
    end
    foreach (t[i]) begin
      queue_byte(t[i], i == t.size() - 1, $urandom_range(0, gap_max));
    end
  endtask

  initial begin
    int random_start;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    snk_stall_max = 5;
    foreach (DIRECTED[i]) begin
      queue_byte(DIRECTED[i][7:0], DIRECTED[i][8] || i == 27, $urandom_range(0, 5));
    end
    wait_quiet();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      snk_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      queue_text($urandom_range(1, 10), ($urandom_range(0, 3) == 0) ? 0 : 5);
      while (text_bytes.size() != 0) begin
        @(posedge clk);
      end
    end
    wait_quiet();
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d texts, directed sequences first and then random ones.",
             bytes_sent, texts_sent);
    $display("Checked %0d results, %0d of them replacements.",
             results_checked, replacements_seen);
    if (err_count == 0) begin
      $display("tb_utf8_stream_decoder passed");
    end else begin
      $display("tb_utf8_stream_decoder failed");
    end
    $finish;
  end

endmodule
